[rtl/tpsm_pkg.sv]
// Shared types and constants of the two-plane stub matcher.
// No dependencies; every other file of the block imports this package.
package tpsm_pkg;

  localparam int PLANE_ONE_DEPTH = 8;
  localparam int PLANE_TWO_DEPTH = 8;
  localparam int EVENT_HITS      = 256;

  localparam int ONE_AW = (PLANE_ONE_DEPTH > 1) ? $clog2(PLANE_ONE_DEPTH) : 1;
  localparam int TWO_AW = (PLANE_TWO_DEPTH > 1) ? $clog2(PLANE_TWO_DEPTH) : 1;
  localparam int ONE_CW = $clog2(PLANE_ONE_DEPTH + 1);
  localparam int TWO_CW = $clog2(PLANE_TWO_DEPTH + 1);
  localparam int IDX_W  = $clog2(EVENT_HITS);

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam int SID_W   = 6;
  localparam int CX_W    = 18;
  localparam int POS_W   = 32;
  localparam int TIME_W  = 32;
  localparam int OIDX_W  = 8;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 18;
  localparam int REG_IDX_W = 3;

  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 152;

  // run modes
  localparam logic [MODE_W-1:0] MODE_MATCH    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP_ONE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DROP_TWO = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STUB = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_RUN_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_ONE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_TWO = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEEP      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RESIDUAL  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STUB_ID   = 3'd5;

  typedef enum logic [1:0] {BK_IDLE, BK_WALK, BK_FLUSH} bk_state_t;

  typedef struct packed {
    logic [MODE_W-1:0] run_mode;
    logic [SID_W-1:0]  plane_one_id;
    logic [SID_W-1:0]  plane_two_id;
    logic              keep_plane_hits;
    logic [CX_W-1:0]   max_residual;
    logic [SID_W-1:0]  stub_sensor_id;
  } cfg_t;

  // one queue entry: a forwarded hit, or an end of event with its snapshot
  typedef struct packed {
    logic              eoe;
    logic [SID_W-1:0]  sensor;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [TIME_W-1:0] tm;
    logic [IDX_W-1:0]  idx;
    logic              ovf;
    logic              match_en;
    logic [ONE_CW-1:0] n1;
    logic [TWO_CW-1:0] n2;
  } q_entry_t;

  typedef struct packed {
    logic              one_we;
    logic [ONE_AW-1:0] one_addr;
    logic              two_we;
    logic [TWO_AW-1:0] two_addr;
    logic [CX_W-1:0]   cx;
    logic [CX_W-1:0]   cy;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
    logic [TIME_W-1:0] tm;
    logic [IDX_W-1:0]  idx;
  } st_wr_t;

  typedef struct packed {
    logic [CX_W-1:0]   one_cx;
    logic [CX_W-1:0]   one_cy;
    logic [POS_W-1:0]  one_px;
    logic [POS_W-1:0]  one_py;
    logic [POS_W-1:0]  one_pz;
    logic [TIME_W-1:0] one_tm;
    logic [IDX_W-1:0]  one_idx;
    logic [CX_W-1:0]   two_cx;
    logic [CX_W-1:0]   two_cy;
    logic [POS_W-1:0]  two_px;
    logic [POS_W-1:0]  two_py;
    logic [POS_W-1:0]  two_pz;
    logic [IDX_W-1:0]  two_idx;
  } st_rd_t;

endpackage

[rtl/two_plane_stub_matcher.sv]
// Two-plane stub matcher, top level: configuration registers, front, queue,
// plane stores and back part. Depends on tpsm_pkg and the tpsm_* modules.
// Hits: one per cycle while the queue has room and no event is in work; a forwarded
// hit passes the queue and the output register. End of event: take the transaction,
// walk plane-one/plane-two pairs, load the final result; no hit is taken until then.
// Reset (rst_n, synchronous) clears control and configuration; stores are not cleared.
module two_plane_stub_matcher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tpsm_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [tpsm_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_tlast,   // command: end of event
  // sensor_id, centroid_x, centroid_y, pos_x, pos_y, pos_z, hit_time, zero pad
  input  logic [tpsm_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic                               out_tlast,  // last
  output logic [tpsm_pkg::KIND_W-1:0]        out_tuser,  // kind
  // out_sensor, out_x, out_y, out_z, out_time, first_index, second_index,
  // overflow, zero pad
  output logic [tpsm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tpsm_pkg::*;

  cfg_t     cfg_r;
  q_entry_t q_entry, q_head;
  st_wr_t   st_wr;
  st_rd_t   st_rd;
  logic     q_push, q_pop, q_empty, q_full, walk_done;
  logic [ONE_AW-1:0] rd_one_addr;
  logic [TWO_AW-1:0] rd_two_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_mode        <= MODE_MATCH;
      cfg_r.plane_one_id    <= SID_W'(6);
      cfg_r.plane_two_id    <= SID_W'(7);
      cfg_r.keep_plane_hits <= 1'b1;
      cfg_r.max_residual    <= '0;
      cfg_r.stub_sensor_id  <= SID_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RUN_MODE:  cfg_r.run_mode        <= cfg_wdata[MODE_W-1:0];
        REG_PLANE_ONE: cfg_r.plane_one_id    <= cfg_wdata[SID_W-1:0];
        REG_PLANE_TWO: cfg_r.plane_two_id    <= cfg_wdata[SID_W-1:0];
        REG_KEEP:      cfg_r.keep_plane_hits <= cfg_wdata[0];
        REG_RESIDUAL:  cfg_r.max_residual    <= cfg_wdata[CX_W-1:0];
        REG_STUB_ID:   cfg_r.stub_sensor_id  <= cfg_wdata[SID_W-1:0];
        default: ;
      endcase
    end
  end

  tpsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .st_wr     (st_wr),
    .walk_done (walk_done)
  );

  tpsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tpsm_store u_store (
    .clk         (clk),
    .wr          (st_wr),
    .rd_one_addr (rd_one_addr),
    .rd_two_addr (rd_two_addr),
    .rd          (st_rd)
  );

  tpsm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .rd_one_addr (rd_one_addr),
    .rd_two_addr (rd_two_addr),
    .rd          (st_rd),
    .walk_done   (walk_done),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

endmodule

[rtl/tpsm_store.sv]
// Plane-one and plane-two hit stores, one write port and one read port each.
// Depends on tpsm_pkg.
module tpsm_store (
  input  logic                   clk,
  input  tpsm_pkg::st_wr_t       wr,
  input  logic [tpsm_pkg::ONE_AW-1:0] rd_one_addr,
  input  logic [tpsm_pkg::TWO_AW-1:0] rd_two_addr,
  output tpsm_pkg::st_rd_t       rd
);
  import tpsm_pkg::*;

  logic [CX_W-1:0]   one_cx_r [PLANE_ONE_DEPTH];
  logic [CX_W-1:0]   one_cy_r [PLANE_ONE_DEPTH];
  logic [POS_W-1:0]  one_px_r [PLANE_ONE_DEPTH];
  logic [POS_W-1:0]  one_py_r [PLANE_ONE_DEPTH];
  logic [POS_W-1:0]  one_pz_r [PLANE_ONE_DEPTH];
  logic [TIME_W-1:0] one_tm_r [PLANE_ONE_DEPTH];
  logic [IDX_W-1:0]  one_idx_r[PLANE_ONE_DEPTH];
  logic [CX_W-1:0]   two_cx_r [PLANE_TWO_DEPTH];
  logic [CX_W-1:0]   two_cy_r [PLANE_TWO_DEPTH];
  logic [POS_W-1:0]  two_px_r [PLANE_TWO_DEPTH];
  logic [POS_W-1:0]  two_py_r [PLANE_TWO_DEPTH];
  logic [POS_W-1:0]  two_pz_r [PLANE_TWO_DEPTH];
  logic [IDX_W-1:0]  two_idx_r[PLANE_TWO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.one_we) begin
      one_cx_r[wr.one_addr]  <= wr.cx;
      one_cy_r[wr.one_addr]  <= wr.cy;
      one_px_r[wr.one_addr]  <= wr.px;
      one_py_r[wr.one_addr]  <= wr.py;
      one_pz_r[wr.one_addr]  <= wr.pz;
      one_tm_r[wr.one_addr]  <= wr.tm;
      one_idx_r[wr.one_addr] <= wr.idx;
    end
    if (wr.two_we) begin
      two_cx_r[wr.two_addr]  <= wr.cx;
      two_cy_r[wr.two_addr]  <= wr.cy;
      two_px_r[wr.two_addr]  <= wr.px;
      two_py_r[wr.two_addr]  <= wr.py;
      two_pz_r[wr.two_addr]  <= wr.pz;
      two_idx_r[wr.two_addr] <= wr.idx;
    end
  end

  always_comb begin
    rd.one_cx  = one_cx_r[rd_one_addr];
    rd.one_cy  = one_cy_r[rd_one_addr];
    rd.one_px  = one_px_r[rd_one_addr];
    rd.one_py  = one_py_r[rd_one_addr];
    rd.one_pz  = one_pz_r[rd_one_addr];
    rd.one_tm  = one_tm_r[rd_one_addr];
    rd.one_idx = one_idx_r[rd_one_addr];
    rd.two_cx  = two_cx_r[rd_two_addr];
    rd.two_cy  = two_cy_r[rd_two_addr];
    rd.two_px  = two_px_r[rd_two_addr];
    rd.two_py  = two_py_r[rd_two_addr];
    rd.two_pz  = two_pz_r[rd_two_addr];
    rd.two_idx = two_idx_r[rd_two_addr];
  end

endmodule

[rtl/tpsm_queue.sv]
// Short FIFO of classified items between the front and back parts.
// Depends on tpsm_pkg.
module tpsm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tpsm_pkg::q_entry_t   push_data,
  input  logic                 pop,
  output tpsm_pkg::q_entry_t   head,
  output logic                 empty,
  output logic                 full
);
  import tpsm_pkg::*;

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == Q_CW'(QUEUE_DEPTH));
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/tpsm_front.sv]
// Front part: accepts input transactions, numbers and classifies hits,
// fills the plane stores and queues forwarded hits and end-of-event items.
// Depends on tpsm_pkg.
module tpsm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tpsm_pkg::cfg_t                cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_tlast,
  input  logic [tpsm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          q_full,
  output logic                          q_push,
  output tpsm_pkg::q_entry_t            q_entry,
  output tpsm_pkg::st_wr_t              st_wr,
  input  logic                          walk_done
);
  import tpsm_pkg::*;

  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [ONE_CW-1:0] cnt1_r, cnt1_nxt;
  logic [TWO_CW-1:0] cnt2_r, cnt2_nxt;
  logic              ovf_r, ovf_nxt;

  logic              accept, is_one, is_two, one_full, two_full;
  logic              one_we, two_we, fwd, ovf_hit;
  logic [SID_W-1:0]  sid;

  assign sid       = in_tdata[5:0];
  assign in_tready = !busy_r && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_one    = (sid == cfg.plane_one_id);
  assign is_two    = (sid == cfg.plane_two_id);
  assign one_full  = (cnt1_r == ONE_CW'(PLANE_ONE_DEPTH));
  assign two_full  = (cnt2_r == TWO_CW'(PLANE_TWO_DEPTH));

  always_comb begin
    one_we  = 1'b0;
    two_we  = 1'b0;
    fwd     = 1'b0;
    ovf_hit = ovf_r;
    unique case (cfg.run_mode)
      MODE_MATCH: begin
        one_we = is_one && !one_full;
        two_we = is_two && !two_full;
        if ((is_one && one_full) || (is_two && two_full)) begin
          ovf_hit = 1'b1;
        end
        fwd = !(is_one || is_two) || cfg.keep_plane_hits;
      end
      MODE_DROP_ONE: fwd = !is_one;
      MODE_DROP_TWO: fwd = !is_two;
      default:       fwd = 1'b0;
    endcase
  end

  always_comb begin
    st_wr.one_we   = accept && !in_tlast && one_we;
    st_wr.two_we   = accept && !in_tlast && two_we;
    st_wr.one_addr = cnt1_r[ONE_AW-1:0];
    st_wr.two_addr = cnt2_r[TWO_AW-1:0];
    st_wr.cx       = in_tdata[23:6];
    st_wr.cy       = in_tdata[41:24];
    st_wr.px       = in_tdata[73:42];
    st_wr.py       = in_tdata[105:74];
    st_wr.pz       = in_tdata[137:106];
    st_wr.tm       = in_tdata[169:138];
    st_wr.idx      = hit_cnt_r;
  end

  always_comb begin
    q_push            = accept && (in_tlast || fwd);
    q_entry.eoe       = in_tlast;
    q_entry.sensor    = sid;
    q_entry.x         = in_tdata[73:42];
    q_entry.y         = in_tdata[105:74];
    q_entry.z         = in_tdata[137:106];
    q_entry.tm        = in_tdata[169:138];
    q_entry.idx       = hit_cnt_r;
    q_entry.ovf       = in_tlast ? ovf_r : ovf_hit;
    q_entry.match_en  = (cfg.run_mode == MODE_MATCH);
    q_entry.n1        = cnt1_r;
    q_entry.n2        = cnt2_r;
  end

  always_comb begin
    busy_nxt    = busy_r;
    hit_cnt_nxt = hit_cnt_r;
    cnt1_nxt    = cnt1_r;
    cnt2_nxt    = cnt2_r;
    ovf_nxt     = ovf_r;
    if (accept) begin
      if (in_tlast) begin
        // hold off new hits until the back part has walked this event's stores
        busy_nxt    = 1'b1;
        hit_cnt_nxt = '0;
        cnt1_nxt    = '0;
        cnt2_nxt    = '0;
        ovf_nxt     = 1'b0;
      end else begin
        hit_cnt_nxt = (hit_cnt_r == IDX_W'(EVENT_HITS - 1)) ? '0 : hit_cnt_r + 1'b1;
        cnt1_nxt    = cnt1_r + ONE_CW'(st_wr.one_we);
        cnt2_nxt    = cnt2_r + TWO_CW'(st_wr.two_we);
        ovf_nxt     = ovf_hit;
      end
    end
    if (walk_done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      hit_cnt_r <= '0;
      cnt1_r    <= '0;
      cnt2_r    <= '0;
      ovf_r     <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      hit_cnt_r <= hit_cnt_nxt;
      cnt1_r    <= cnt1_nxt;
      cnt2_r    <= cnt2_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

endmodule

[rtl/tpsm_back.sv]
// Back part: drains the queue, walks plane-one by plane-two pairs at end of
// event, and drives the registered output channel. Depends on tpsm_pkg.
module tpsm_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpsm_pkg::cfg_t                 cfg,
  input  logic                           q_empty,
  input  tpsm_pkg::q_entry_t             q_head,
  output logic                           q_pop,
  output logic [tpsm_pkg::ONE_AW-1:0]    rd_one_addr,
  output logic [tpsm_pkg::TWO_AW-1:0]    rd_two_addr,
  input  tpsm_pkg::st_rd_t               rd,
  output logic                           walk_done,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_tlast,
  output logic [tpsm_pkg::KIND_W-1:0]    out_tuser,
  output logic [tpsm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tpsm_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [ONE_AW-1:0] i_r;
  logic [TWO_AW-1:0] j_r;
  logic [ONE_CW-1:0] n1_r;
  logic [TWO_CW-1:0] n2_r;
  logic              ovf_r;

  logic              pend_vld_r;
  logic [POS_W-1:0]  pend_x_r, pend_y_r, pend_z_r;
  logic [TIME_W-1:0] pend_tm_r;
  logic [IDX_W-1:0]  pend_i1_r, pend_i2_r;

  logic              out_vld_r;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [SID_W-1:0]  out_sid_r, out_sid_nxt;
  logic [POS_W-1:0]  out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic [TIME_W-1:0] out_tm_r, out_tm_nxt;
  logic [IDX_W-1:0]  out_i1_r, out_i1_nxt, out_i2_r, out_i2_nxt;
  logic              out_ovf_r, out_ovf_nxt, out_last_r, out_last_nxt;

  logic              can_load, ld_out, pend_ld, pend_clr, latch, step;
  logic              head_hit, head_eoe, match, i_end, j_end;
  logic [CX_W-1:0]   dx, dy;
  logic [POS_W:0]    sum_x, sum_y, sum_z;

  assign rd_one_addr = i_r;
  assign rd_two_addr = j_r;

  assign can_load = !out_vld_r || out_tready;
  assign head_hit = !q_empty && !q_head.eoe;
  assign head_eoe = !q_empty && q_head.eoe;

  // pair evaluation for the current (i, j)
  assign dx    = (rd.one_cx > rd.two_cx) ? rd.one_cx - rd.two_cx : rd.two_cx - rd.one_cx;
  assign dy    = (rd.one_cy > rd.two_cy) ? rd.one_cy - rd.two_cy : rd.two_cy - rd.one_cy;
  assign match = (dx < cfg.max_residual) && (dy < cfg.max_residual);
  // sign-extended sum; dropping the low bit is the floor of the half
  assign sum_x = {rd.one_px[POS_W-1], rd.one_px} + {rd.two_px[POS_W-1], rd.two_px};
  assign sum_y = {rd.one_py[POS_W-1], rd.one_py} + {rd.two_py[POS_W-1], rd.two_py};
  assign sum_z = {rd.one_pz[POS_W-1], rd.one_pz} + {rd.two_pz[POS_W-1], rd.two_pz};

  assign i_end = (ONE_CW'(i_r) == n1_r - ONE_CW'(1));
  assign j_end = (TWO_CW'(j_r) == n2_r - TWO_CW'(1));
  assign step  = (state_r == BK_WALK) && (!match || !pend_vld_r || can_load);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head_eoe) begin
          state_nxt = (q_head.match_en && q_head.n1 != '0 && q_head.n2 != '0) ?
                      BK_WALK : BK_FLUSH;
        end
      end
      BK_WALK: begin
        if (step && i_end && j_end) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (can_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control and output payload
  always_comb begin
    q_pop        = 1'b0;
    latch        = 1'b0;
    ld_out       = 1'b0;
    pend_ld      = 1'b0;
    pend_clr     = 1'b0;
    walk_done    = 1'b0;
    out_kind_nxt = KIND_STUB;
    out_sid_nxt  = cfg.stub_sensor_id;
    out_x_nxt    = pend_x_r;
    out_y_nxt    = pend_y_r;
    out_z_nxt    = pend_z_r;
    out_tm_nxt   = pend_tm_r;
    out_i1_nxt   = pend_i1_r;
    out_i2_nxt   = pend_i2_r;
    out_ovf_nxt  = ovf_r;
    out_last_nxt = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (head_hit && can_load) begin
          q_pop        = 1'b1;
          ld_out       = 1'b1;
          out_kind_nxt = KIND_HIT;
          out_sid_nxt  = q_head.sensor;
          out_x_nxt    = q_head.x;
          out_y_nxt    = q_head.y;
          out_z_nxt    = q_head.z;
          out_tm_nxt   = q_head.tm;
          out_i1_nxt   = q_head.idx;
          out_i2_nxt   = '0;
          out_ovf_nxt  = q_head.ovf;
        end else if (head_eoe) begin
          q_pop = 1'b1;
          latch = 1'b1;
        end
      end
      BK_WALK: begin
        // a new stub pushes the held one out; the last one is held for flush
        if (step && match) begin
          pend_ld = 1'b1;
          ld_out  = pend_vld_r;
        end
      end
      BK_FLUSH: begin
        if (can_load) begin
          ld_out       = 1'b1;
          pend_clr     = 1'b1;
          walk_done    = 1'b1;
          out_last_nxt = 1'b1;
          if (!pend_vld_r) begin
            out_kind_nxt = KIND_END;
            out_sid_nxt  = '0;
            out_x_nxt    = '0;
            out_y_nxt    = '0;
            out_z_nxt    = '0;
            out_tm_nxt   = '0;
            out_i1_nxt   = '0;
            out_i2_nxt   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ld_out) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (pend_ld) begin
        pend_vld_r <= 1'b1;
      end else if (pend_clr || latch) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      i_r   <= '0;
      j_r   <= '0;
      n1_r  <= q_head.n1;
      n2_r  <= q_head.n2;
      ovf_r <= q_head.ovf;
    end else if (step) begin
      if (j_end) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
    if (pend_ld) begin
      pend_x_r  <= sum_x[POS_W:1];
      pend_y_r  <= sum_y[POS_W:1];
      pend_z_r  <= sum_z[POS_W:1];
      pend_tm_r <= rd.one_tm;
      pend_i1_r <= rd.one_idx;
      pend_i2_r <= rd.two_idx;
    end
    if (ld_out) begin
      out_kind_r <= out_kind_nxt;
      out_sid_r  <= out_sid_nxt;
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_z_r    <= out_z_nxt;
      out_tm_r   <= out_tm_nxt;
      out_i1_r   <= out_i1_nxt;
      out_i2_r   <= out_i2_nxt;
      out_ovf_r  <= out_ovf_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_ovf_r, OIDX_W'(out_i2_r), OIDX_W'(out_i1_r), out_tm_r,
                       out_z_r, out_y_r, out_x_r, out_sid_r};

endmodule

[verif/two_plane_stub_matcher_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for two_plane_stub_matcher: forwarding, plane stores and
// end-of-event stub building are predicted per transaction and checked in order.
// Depends on tpsm_pkg and the RTL of the block.
module two_plane_stub_matcher_test;
  import tpsm_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 2000000;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    bit                eoe;
    logic [SID_W-1:0]  sid;
    logic [CX_W-1:0]   cx;
    logic [CX_W-1:0]   cy;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
    logic [TIME_W-1:0] tm;
  } hit_item_t;

  typedef struct {
    logic [CX_W-1:0]   cx;
    logic [CX_W-1:0]   cy;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [POS_W-1:0]  pz;
    logic [TIME_W-1:0] tm;
    logic [OIDX_W-1:0] idx;
  } plane_hit_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SID_W-1:0]  sensor;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [POS_W-1:0]  z;
    logic [TIME_W-1:0] tm;
    logic [OIDX_W-1:0] first_idx;
    logic [OIDX_W-1:0] second_idx;
    logic              ovf;
    logic              last;
  } result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [REG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic                   in_tlast;   // command: end of event
  // sensor_id, centroid_x, centroid_y, pos_x, pos_y, pos_z, hit_time, zero pad
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   out_tlast;  // last
  logic [KIND_W-1:0]      out_tuser;  // kind
  // out_sensor, out_x, out_y, out_z, out_time, first_index, second_index,
  // overflow, zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;

  // register shadow
  logic [MODE_W-1:0] cur_mode;
  logic [SID_W-1:0]  one_id;
  logic [SID_W-1:0]  two_id;
  logic              keep_hits;
  logic [CX_W-1:0]   window;
  logic [SID_W-1:0]  stub_id;

  // event state of the predictor
  plane_hit_t one_store[PLANE_ONE_DEPTH];
  plane_hit_t two_store[PLANE_TWO_DEPTH];
  int         one_cnt;
  int         two_cnt;
  int         evt_index;
  logic       ovf_seen;

  result_t expected_results[$];

  int  items_sent;
  int  results_seen;
  int  stubs_seen;
  int  markers_seen;
  int  error_count;
  int  reports;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_request;
  bit  holding;

  two_plane_stub_matcher DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // long output hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      wait (hold_request);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
      hold_request = 1'b0;
    end
  end

  always @(negedge clk)
    out_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);

  function automatic logic [CX_W-1:0] centroid_gap(logic [CX_W-1:0] a, logic [CX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // floor halving of a signed sum: arithmetic shift of the 33-bit sum
  function automatic logic [POS_W-1:0] mean_floor(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic signed [POS_W:0] s;
    s = $signed({a[POS_W-1], a}) + $signed({b[POS_W-1], b});
    return s[POS_W:1];
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endfunction

  task automatic predict_results(input hit_item_t it);
    result_t          r;
    logic [OIDX_W-1:0] idx;
    bit               plane;
    bit               fwd;
    int               found;
    plane_hit_t       h;
    if (!it.eoe) begin
      idx = evt_index[OIDX_W-1:0];
      evt_index = (evt_index + 1) % EVENT_HITS;
      fwd = 1'b0;
      h = '{it.cx, it.cy, it.px, it.py, it.pz, it.tm, idx};
      case (cur_mode)
        MODE_MATCH: begin
          plane = 1'b0;
          if (it.sid == one_id) begin
            plane = 1'b1;
            if (one_cnt < PLANE_ONE_DEPTH) begin
              one_store[one_cnt] = h;
              one_cnt++;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          if (it.sid == two_id) begin
            plane = 1'b1;
            if (two_cnt < PLANE_TWO_DEPTH) begin
              two_store[two_cnt] = h;
              two_cnt++;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          fwd = !plane || keep_hits;
        end
        MODE_DROP_ONE: fwd = (it.sid != one_id);
        MODE_DROP_TWO: fwd = (it.sid != two_id);
        default:       fwd = 1'b0;
      endcase
      if (fwd) begin
        r = '{KIND_HIT, it.sid, it.px, it.py, it.pz, it.tm, idx, '0, ovf_seen, 1'b0};
        expected_results.insert(expected_results.size(), r);
      end
    end else begin
      found = 0;
      if (cur_mode == MODE_MATCH) begin
        for (int i = 0; i < one_cnt; i++) begin
          for (int j = 0; j < two_cnt; j++) begin
            if (centroid_gap(one_store[i].cx, two_store[j].cx) < window &&
                centroid_gap(one_store[i].cy, two_store[j].cy) < window) begin
              r = '{KIND_STUB, stub_id,
                    mean_floor(one_store[i].px, two_store[j].px),
                    mean_floor(one_store[i].py, two_store[j].py),
                    mean_floor(one_store[i].pz, two_store[j].pz),
                    one_store[i].tm, one_store[i].idx, two_store[j].idx, ovf_seen, 1'b0};
              expected_results.insert(expected_results.size(), r);
              found++;
            end
          end
        end
      end
      if (found == 0) begin
        r = '{KIND_END, '0, '0, '0, '0, '0, '0, '0, ovf_seen, 1'b1};
        expected_results.insert(expected_results.size(), r);
      end else begin
        expected_results[expected_results.size() - 1].last = 1'b1;
      end
      one_cnt = 0;
      two_cnt = 0;
      evt_index = 0;
      ovf_seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind       = out_tuser;
      got.sensor     = out_tdata[5:0];
      got.x          = out_tdata[37:6];
      got.y          = out_tdata[69:38];
      got.z          = out_tdata[101:70];
      got.tm         = out_tdata[133:102];
      got.first_idx  = out_tdata[141:134];
      got.second_idx = out_tdata[149:142];
      got.ovf        = out_tdata[150];
      got.last       = out_tlast;
      results_seen++;
      if (got.kind == KIND_STUB) stubs_seen++;
      if (got.kind == KIND_END) markers_seen++;
      if (expected_results.size() == 0) begin
        error_count++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t unexpected result: expected none, actual kind %0d tdata %h",
                   $time, got.kind, out_tdata);
        end
      end else begin
        want = expected_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("out_sensor", want.sensor, got.sensor);
        check_field("out_x", want.x, got.x);
        check_field("out_y", want.y, got.y);
        check_field("out_z", want.z, got.z);
        check_field("out_time", want.tm, got.tm);
        check_field("first_index", want.first_idx, got.first_idx);
        check_field("second_index", want.second_idx, got.second_idx);
        check_field("overflow", want.ovf, got.ovf);
        check_field("last", want.last, got.last);
      end
    end
  end

  function automatic hit_item_t make_hit(logic [SID_W-1:0] sid, logic [CX_W-1:0] cx,
                                         logic [CX_W-1:0] cy);
    hit_item_t it;
    it.eoe = 1'b0;
    it.sid = sid;
    it.cx  = cx;
    it.cy  = cy;
    it.px  = $urandom;
    it.py  = $urandom;
    it.pz  = $urandom;
    it.tm  = $urandom;
    return it;
  endfunction

  // end of event with junk in the ignored fields
  function automatic hit_item_t make_end();
    hit_item_t it;
    it = make_hit($urandom_range(63), $urandom_range(262143), $urandom_range(262143));
    it.eoe = 1'b1;
    return it;
  endfunction

  // called and returns just after a falling edge
  task automatic push_item(input hit_item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tlast  <= it.eoe;
    in_tdata  <= {{(IN_TDATA_W - 170){1'b0}}, it.tm, it.pz, it.py, it.px, it.cy, it.cx, it.sid};
    do @(posedge clk); while (!in_tready);
    predict_results(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (index)
      REG_RUN_MODE:  cur_mode  = value[MODE_W-1:0];
      REG_PLANE_ONE: one_id    = value[SID_W-1:0];
      REG_PLANE_TWO: two_id    = value[SID_W-1:0];
      REG_KEEP:      keep_hits = value[0];
      REG_RESIDUAL:  window    = value[CX_W-1:0];
      REG_STUB_ID:   stub_id   = value[SID_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [SID_W-1:0] p1,
                              input logic [SID_W-1:0] p2, input logic keep,
                              input logic [CX_W-1:0] res, input logic [SID_W-1:0] stub);
    write_reg(REG_RUN_MODE, mode);
    write_reg(REG_PLANE_ONE, p1);
    write_reg(REG_PLANE_TWO, p2);
    write_reg(REG_KEEP, keep);
    write_reg(REG_RESIDUAL, res);
    write_reg(REG_STUB_ID, stub);
  endtask

  // one event: mostly plane hits clustered around a common centroid, some noise
  task automatic random_event();
    int               n_hits;
    int               r;
    int               span;
    logic [CX_W-1:0]  base_x;
    logic [CX_W-1:0]  base_y;
    logic [SID_W-1:0] sid;
    hit_item_t        it;
    n_hits = ($urandom_range(99) < 12) ? $urandom_range(9, 14) : $urandom_range(0, 7);
    span   = (window > 0) ? window : 16;
    base_x = $urandom_range(262143);
    base_y = $urandom_range(262143);
    repeat (n_hits) begin
      r = $urandom_range(99);
      sid = (r < 40) ? one_id : (r < 80) ? two_id : $urandom_range(63);
      if ($urandom_range(99) < 20)
        it = make_hit(sid, $urandom_range(262143), $urandom_range(262143));
      else
        it = make_hit(sid, base_x + $urandom_range(span), base_y + $urandom_range(span));
      push_item(it);
    end
    push_item(make_end());
  endtask

  task automatic test_reset_defaults();
    push_item(make_hit(6, 100, 100));
    push_item(make_hit(7, 100, 100));
    push_item(make_hit(30, 5, 5));
    // zero window: nothing can match, so no stub, only the end marker after the forwarded hits
    push_item(make_end());
    wait_drained();
  endtask

  task automatic test_mode_gating();
    write_reg(REG_RESIDUAL, 18'h3FFFF);
    push_item(make_hit(6, 100, 100));
    push_item(make_hit(7, 100, 100));
    wait_drained();
    // stored pair must not match once the mode has left matching
    write_reg(REG_RUN_MODE, MODE_DROP_ONE);
    push_item(make_end());
    push_item(make_hit(6, 1, 1));
    push_item(make_hit(7, 1, 1));
    push_item(make_hit(40, 1, 1));
    push_item(make_end());
    wait_drained();
    write_reg(REG_RUN_MODE, MODE_DROP_TWO);
    push_item(make_hit(6, 1, 1));
    push_item(make_hit(7, 1, 1));
    push_item(make_end());
    wait_drained();
    // undefined mode drops every hit
    write_reg(REG_RUN_MODE, 2'b11);
    push_item(make_hit(6, 1, 1));
    push_item(make_hit(40, 1, 1));
    push_item(make_end());
    wait_drained();
  endtask

  task automatic test_match_extremes();
    hit_item_t it;
    apply_config(MODE_MATCH, 0, 63, 1'b0, 18'h3FFFF, 63);
    it = make_hit(0, 0, 0);
    it.px = 32'h7FFFFFFF; it.py = 32'h80000000; it.pz = 32'hFFFFFFFF; it.tm = 32'hFFFFFFFF;
    push_item(it);
    it = make_hit(63, 18'h3FFFE, 18'h3FFFE);
    it.px = 32'h7FFFFFFF; it.py = 32'h80000000; it.pz = 32'h0; it.tm = 32'h0;
    push_item(it);
    // differences equal to the window fail the strict compare
    push_item(make_hit(63, 18'h3FFFF, 0));
    push_item(make_hit(63, 0, 18'h3FFFF));
    push_item(make_end());
    wait_drained();
  endtask

  task automatic test_equal_planes();
    apply_config(MODE_MATCH, 20, 20, 1'b1, 1, 0);
    push_item(make_hit(20, 0, 0));
    push_item(make_hit(20, 1, 0));
    push_item(make_end());
    wait_drained();
  endtask

  task automatic test_full_stores();
    apply_config(MODE_MATCH, 10, 11, 1'b0, 18'h3FFFF, 45);
    recv_stall_pct = 50;
    repeat (PLANE_ONE_DEPTH + 1) begin
      push_item(make_hit(10, $urandom_range(1000), $urandom_range(1000)));
      push_item(make_hit(11, $urandom_range(1000), $urandom_range(1000)));
    end
    push_item(make_end());
    wait_drained();
    recv_stall_pct = 0;
  endtask

  task automatic test_index_wrap();
    apply_config(MODE_MATCH, 1, 2, 1'b1, 18'h3FFFF, 50);
    push_item(make_hit(1, 7, 7));
    for (int k = 1; k < EVENT_HITS + 2; k++) begin
      if (k >= EVENT_HITS - 2)
        push_item(make_hit((k % 2) ? 2 : 1, 9, 9));
      else
        push_item(make_hit($urandom_range(3, 63), $urandom_range(262143), $urandom_range(262143)));
    end
    push_item(make_end());
    wait_drained();
  endtask

  task automatic test_backpressure();
    apply_config(MODE_MATCH, 3, 4, 1'b1, 5000, 17);
    hold_request = 1'b1;
    repeat (8) begin
      push_item(make_hit(3, 20000 + $urandom_range(6000), 20000 + $urandom_range(6000)));
      push_item(make_hit(4, 20000 + $urandom_range(6000), 20000 + $urandom_range(6000)));
    end
    push_item(make_end());
    wait_drained();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int n_items);
    int stop_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) random_event();
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tlast       = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    hold_request   = 1'b0;
    holding        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_mode       = MODE_MATCH;
    one_id         = 6;
    two_id         = 7;
    keep_hits      = 1'b1;
    window         = '0;
    stub_id        = 8;
    one_cnt        = 0;
    two_cnt        = 0;
    evt_index      = 0;
    ovf_seen       = 1'b0;
    items_sent     = 0;
    results_seen   = 0;
    stubs_seen     = 0;
    markers_seen   = 0;
    error_count    = 0;
    reports        = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_mode_gating();
    test_match_extremes();
    test_equal_planes();
    test_full_stores();
    test_index_wrap();
    test_backpressure();

    apply_config(MODE_MATCH, 0, 63, 1'b1, 2048, 63);
    test_random_phase(0, 0, 50);
    apply_config(MODE_MATCH, 63, 0, 1'b0, 600, 0);
    test_random_phase(82, 0, 50);
    apply_config(MODE_DROP_TWO, 5, 9, 1'b1, 18'h3FFFF, 33);
    test_random_phase(0, 82, 50);
    apply_config(MODE_MATCH, 12, 12, 1'b1, 1500, 21);
    test_random_phase(37, 37, 50);
    apply_config(MODE_DROP_ONE, 9, 5, 1'b0, 0, 0);
    test_random_phase(37, 82, 50);

    $display("Run covered %0d input transactions: all run modes, full stores, index wrap,",
             items_sent);
    $display("shared plane ids and a long output hold; %0d results (%0d stubs, %0d end markers).",
             results_seen, stubs_seen, markers_seen);
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
